>>> rtl/rat_pkg.sv
// Package for the rational accumulator ALU: opcodes, controller states,
// command and status structs. No dependencies.
package rat_pkg;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_ADDI = 3'd5,
    OP_SUBI = 3'd6,
    OP_MULI = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_WHOLE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DV_NONE,
    DV_GCD,
    DV_NUM,
    DV_DEN,
    DV_WHOLE
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul1;
    logic     mul2;
    logic     comb;
    logic     gcd_step;
    div_sel_t div_start;
    logic     div_take;
    logic     commit;
    logic     set_err;
  } cmd_t;

  typedef struct packed {
    logic nd_zero;
    logic gcd_done;
    logic div_busy;
    logic div_done;
  } sts_t;

endpackage

>>> rtl/rat_div.sv
// Iterative signed truncating divider, one quotient bit per cycle.
// Depends on rat_pkg for nothing; standalone unit.
module rat_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q_r, r_r, d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r, qneg_r, rneg_r;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] rs;

  always_comb begin
    rs    = {r_r[WIDTH-2:0], q_r[WIDTH-1]};
    trial = {1'b0, rs} - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
        q_r    <= a[WIDTH-1] ? -a : a;
        d_r    <= b[WIDTH-1] ? -b : b;
        r_r    <= '0;
        qneg_r <= a[WIDTH-1] ^ b[WIDTH-1];
        rneg_r <= a[WIDTH-1];
      end else if (busy_r) begin
        if (!trial[WIDTH]) begin
          r_r <= trial[WIDTH-1:0];
          q_r <= {q_r[WIDTH-2:0], 1'b1};
        end else begin
          r_r <= rs;
          q_r <= {q_r[WIDTH-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -r_r : r_r;
endmodule

>>> rtl/rat_dp.sv
// Datapath: accumulator, operand products, gcd loop and divider.
// Depends on rat_pkg and rat_div.
module rat_dp #(
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rat_pkg::cmd_t         cmd,
  output rat_pkg::sts_t         sts,
  input  logic [2:0]            in_opcode,
  input  logic signed [31:0]    in_operand_num,
  input  logic signed [31:0]    in_operand_den,
  output logic signed [31:0]    out_result_num,
  output logic signed [31:0]    out_result_den,
  output logic signed [31:0]    out_whole_part,
  output logic signed [31:0]    out_remainder_part,
  output logic                  out_error_flag
);
  import rat_pkg::*;

  logic [WIDTH-1:0] n_r, d_r, x_r, y_r, p1_r, p2_r, p3_r, nn_r, nd_r;
  logic [WIDTH-1:0] ga_r, gb_r, g_r, qn_r, q_r, rm_r;
  opcode_t          op_r;
  logic             err_r;
  logic             seed_r;
  logic             dstart;
  logic [WIDTH-1:0] da, db, dq, drm;
  logic             dbusy, ddone;
  logic [WIDTH-1:0] mxa, mxb, prod;

  always_comb begin
    mxa = n_r;
    mxb = y_r;
    if (cmd.mul2) begin
      mxa = x_r;
      mxb = d_r;
    end
    prod = WIDTH'(mxa * mxb);
  end

  always_comb begin
    dstart = 1'b0;
    da = ga_r;
    db = gb_r;
    case (cmd.div_start)
      DV_GCD:   begin dstart = 1'b1; end
      DV_NUM:   begin dstart = 1'b1; da = nn_r; db = g_r; end
      DV_DEN:   begin dstart = 1'b1; da = nd_r; db = g_r; end
      DV_WHOLE: begin dstart = 1'b1; da = n_r; db = d_r; end
      default: ;
    endcase
  end

  rat_div #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .a(da), .b(db),
    .busy(dbusy), .done(ddone), .quot(dq), .rem(drm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      d_r   <= WIDTH'(1);
      err_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        op_r  <= opcode_t'(in_opcode);
        x_r   <= WIDTH'(64'(in_operand_num));
        y_r   <= WIDTH'(64'(in_operand_den));
        err_r <= 1'b0;
      end
      if (cmd.mul1) begin
        p1_r <= prod;
        p3_r <= WIDTH'(d_r * (op_r == OP_DIV ? x_r : y_r));
      end
      if (cmd.mul2) p2_r <= prod;
      if (cmd.comb) begin
        unique case (op_r)
          OP_LOAD: begin nn_r <= x_r; nd_r <= y_r; end
          OP_ADD:  begin nn_r <= p1_r + p2_r; nd_r <= p3_r; end
          OP_SUB:  begin nn_r <= p1_r - p2_r; nd_r <= p3_r; end
          OP_MUL:  begin nn_r <= WIDTH'(n_r * x_r); nd_r <= p3_r; end
          OP_DIV:  begin nn_r <= p1_r; nd_r <= p3_r; end
          OP_ADDI: begin nn_r <= n_r + p2_r; nd_r <= d_r; end
          OP_SUBI: begin nn_r <= n_r - p2_r; nd_r <= d_r; end
          default: begin nn_r <= WIDTH'(n_r * x_r); nd_r <= d_r; end
        endcase
      end
      if (seed_r) begin
        ga_r <= nn_r;
        gb_r <= nd_r;
      end
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.gcd_step) begin
        if (gb_r == '0) g_r <= ga_r;
      end
      if (cmd.div_take) begin
        unique case (cmd.div_start)
          DV_GCD: begin ga_r <= gb_r; gb_r <= (&gb_r) ? '0 : drm; end
          DV_NUM: qn_r <= ((&g_r)) ? -nn_r : dq;
          DV_WHOLE: begin
            rm_r <= (&d_r) ? '0 : drm;
            q_r  <= (&d_r) ? -n_r : dq;
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        n_r <= qn_r;
        d_r <= dq;
      end
    end
  end

  // seed gcd operands from the combined fraction once it is registered
  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 1'b0;
    else        seed_r <= cmd.comb;
  end

  assign sts.nd_zero  = (nd_r == '0);
  assign sts.gcd_done = (gb_r == '0);
  assign sts.div_busy = dbusy;
  assign sts.div_done = ddone;

  assign out_result_num     = 32'(64'(n_r));
  assign out_result_den     = 32'(64'(d_r));
  assign out_whole_part     = 32'(64'(q_r));
  assign out_remainder_part = 32'(64'(rm_r));
  assign out_error_flag     = err_r;
endmodule

>>> rtl/rat_ctrl.sv
// Controller state machine sequencing products, gcd and output division.
// Depends on rat_pkg.
module rat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rat_pkg::sts_t sts,
  output rat_pkg::cmd_t cmd
);
  import rat_pkg::*;

  state_t st_r, st_nxt;
  logic   wait_r, wait_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      wait_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    wait_nxt = wait_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid) st_nxt = ST_MUL1;
      ST_MUL1:  st_nxt = ST_MUL2;
      ST_MUL2:  st_nxt = ST_COMB;
      ST_COMB:  st_nxt = ST_CHECK;
      ST_CHECK: st_nxt = sts.nd_zero ? ST_WHOLE : ST_GCD;
      ST_GCD: begin
        if (!wait_r) begin
          if (sts.gcd_done) st_nxt = ST_DIVN;
          else wait_nxt = 1'b1;
        end else if (sts.div_done) wait_nxt = 1'b0;
      end
      ST_DIVN: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (sts.div_done) begin wait_nxt = 1'b0; st_nxt = ST_DIVD; end
      end
      ST_DIVD: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (sts.div_done) begin wait_nxt = 1'b0; st_nxt = ST_WHOLE; end
      end
      ST_WHOLE: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (sts.div_done) begin wait_nxt = 1'b0; st_nxt = ST_OUT; end
      end
      ST_OUT:   if (!out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = (st_r != ST_IDLE);
    out_valid = (st_r == ST_OUT);
    unique case (st_r)
      ST_IDLE:  cmd.load_in = in_valid;
      ST_MUL1:  cmd.mul1 = 1'b1;
      ST_MUL2:  cmd.mul2 = 1'b1;
      ST_COMB:  cmd.comb = 1'b1;
      ST_CHECK: cmd.set_err = sts.nd_zero;
      ST_GCD: begin
        cmd.gcd_step = !wait_r;
        if (!wait_r && !sts.gcd_done) cmd.div_start = DV_GCD;
        if (wait_r) begin
          cmd.div_start = sts.div_done ? DV_GCD : DV_NONE;
          cmd.div_take  = sts.div_done;
        end
      end
      ST_DIVN: begin
        if (!wait_r || sts.div_done) cmd.div_start = DV_NUM;
        cmd.div_take = wait_r && sts.div_done;
      end
      ST_DIVD: begin
        if (!wait_r || sts.div_done) cmd.div_start = DV_DEN;
        cmd.div_take = wait_r && sts.div_done;
        cmd.commit   = wait_r && sts.div_done;
      end
      ST_WHOLE: begin
        if (!wait_r || sts.div_done) cmd.div_start = DV_WHOLE;
        cmd.div_take = wait_r && sts.div_done;
      end
      ST_OUT: ;
      default: ;
    endcase
  end
endmodule

>>> rtl/rational_accumulator_alu.sv
// Rational accumulator ALU top level: controller plus datapath.
// The bit-serial divider is shared by the gcd loop, the reduction and the
// whole part. Throughput: one item at a time; next item accepted after the
// result beat.
// Reset (rst_n, synchronous, active low): accumulator 0/1, controller idle.
module rational_accumulator_alu #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_operand_num,
  input  logic signed [31:0] in_operand_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_num,
  output logic signed [31:0] out_result_den,
  output logic signed [31:0] out_whole_part,
  output logic signed [31:0] out_remainder_part,
  output logic               out_error_flag
);
  import rat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  rat_dp #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_operand_num(in_operand_num),
    .in_operand_den(in_operand_den),
    .out_result_num(out_result_num), .out_result_den(out_result_den),
    .out_whole_part(out_whole_part), .out_remainder_part(out_remainder_part),
    .out_error_flag(out_error_flag)
  );
endmodule
